/* rtl/core/sample_word_to_double_unit_defines.svh */
// ----------------------------------------------------------------------------
// sample word to double unit assertion macros
// concurrent assertion wrappers, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef SAMPLE_WORD_TO_DOUBLE_UNIT_DEFINES_SVH
`define SAMPLE_WORD_TO_DOUBLE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SWD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SWD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SWD_ASSERT(lbl, clk, rst_n, prop)
`define SWD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/core/swd_pkg.sv */
// ----------------------------------------------------------------------------
// swd package
// shared types and constants of the sample word to double unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package swd_pkg;
    localparam logic [1:0] REG_BIG_ENDIAN = 2'd0;
    localparam logic [1:0] REG_WORD_BYTES = 2'd1;
    localparam logic [1:0] REG_IS_FLOAT   = 2'd2;

    localparam logic [2:0] K_ZERO = 3'd0;
    localparam logic [2:0] K_INT  = 3'd1;
    localparam logic [2:0] K_HALF = 3'd2;
    localparam logic [2:0] K_SGL  = 3'd3;
    localparam logic [2:0] K_DBL  = 3'd4;

    typedef struct packed {
        logic       big_endian;
        logic [3:0] word_bytes;
        logic       is_float;
    } t_cfg;
endpackage

/* rtl/core/swd_conv.sv */
// ----------------------------------------------------------------------------
// swd conversion pipeline
// four stage word to double converter with stall-aware valid chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module swd_conv
    import swd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  logic [63:0] i_raw_word,
    input  logic        i_last_word,
    output logic        o_stall,
    output logic        o_valid,
    output logic [63:0] o_value_bits,
    output logic        o_last_value,
    input  logic        i_stall
);
    logic       adv;
    logic [3:0] r_vld;
    logic       n_neg;
    logic [63:0] n_w;
    logic [2:0] n_kind;

    assign adv     = !(r_vld[3] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // stage 1: swap, mask, classify, signed magnitude
    logic [63:0] sw;
    logic [2:0]  kind;
    always_comb begin
        sw = i_raw_word;
        kind = K_ZERO;
        unique case (i_cfg.word_bytes)
            4'd1: begin
                sw = {56'd0, i_raw_word[7:0]};
                kind = i_cfg.is_float ? K_ZERO : K_INT;
            end
            4'd2: begin
                sw = i_cfg.big_endian ? {48'd0, i_raw_word[7:0], i_raw_word[15:8]}
                                      : {48'd0, i_raw_word[15:0]};
                kind = i_cfg.is_float ? K_HALF : K_INT;
            end
            4'd4: begin
                sw = i_cfg.big_endian ? {32'd0, i_raw_word[7:0], i_raw_word[15:8],
                                         i_raw_word[23:16], i_raw_word[31:24]}
                                      : {32'd0, i_raw_word[31:0]};
                kind = i_cfg.is_float ? K_SGL : K_INT;
            end
            4'd8: begin
                for (int i = 0; i < 8; i++) begin
                    sw[8*i +: 8] = i_cfg.big_endian ? i_raw_word[8*(7-i) +: 8]
                                                    : i_raw_word[8*i +: 8];
                end
                kind = i_cfg.is_float ? K_DBL : K_INT;
            end
            default: kind = K_ZERO;
        endcase
    end

    // integer: left-align to 64 bits so value = s / 2^63
    // half and single float: sign split off so the leading zero count sees the magnitude only
    logic [63:0] al;
    always_comb begin
        unique case (i_cfg.word_bytes)
            4'd1:    al = {sw[7:0], 56'd0};
            4'd2:    al = {sw[15:0], 48'd0};
            4'd4:    al = {sw[31:0], 32'd0};
            default: al = sw;
        endcase
        n_neg = 1'b0;
        n_w   = sw;
        case (kind)
            K_INT: begin
                n_neg = al[63];
                n_w   = al[63] ? (64'd0 - al) : al;
            end
            K_HALF: begin
                n_neg = sw[15];
                n_w   = {48'd0, 1'b0, sw[14:0]};
            end
            K_SGL: begin
                n_neg = sw[31];
                n_w   = {32'd0, 1'b0, sw[30:0]};
            end
            default: ;
        endcase
        n_kind = kind;
    end

    logic [63:0] r1_w;  logic r1_neg; logic [2:0] r1_k; logic r1_l;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_w <= n_w; r1_neg <= n_neg; r1_k <= n_kind; r1_l <= i_last_word;
        end
    end

    // stage 2: leading zero count
    logic [6:0] lz;
    logic       lzf;
    always_comb begin
        lz = 7'd64; lzf = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (r1_w[i] && !lzf) begin
                lz = 7'(63 - i); lzf = 1'b1;
            end
        end
    end
    logic [63:0] r2_w;  logic r2_neg; logic [2:0] r2_k; logic r2_l; logic [6:0] r2_lz;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_w <= r1_w; r2_neg <= r1_neg; r2_k <= r1_k; r2_l <= r1_l; r2_lz <= lz;
        end
    end

    // stage 3: normalise
    logic [63:0] nm;
    assign nm = r2_w << r2_lz[5:0];
    logic [63:0] r3_w;  logic [63:0] r3_nm; logic r3_neg; logic [2:0] r3_k;
    logic r3_l; logic [6:0] r3_lz;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_w <= r2_w; r3_nm <= nm; r3_neg <= r2_neg; r3_k <= r2_k;
            r3_l <= r2_l; r3_lz <= r2_lz;
        end
    end

    // stage 4: round and pack
    logic [63:0] res;
    logic [53:0] mr;
    logic        rup;
    logic [10:0] ex;
    logic [7:0]  se;
    logic [22:0] sm;
    logic [9:0]  hm;
    logic [4:0]  he;
    always_comb begin
        res = 64'd0;
        mr = '0; rup = 1'b0; ex = '0;
        se = r3_w[30:23]; sm = r3_w[22:0];
        hm = r3_w[9:0];   he = r3_w[14:10];
        case (r3_k)
            K_INT: begin
                if (!r3_lz[6]) begin
                    rup = r3_nm[10] && (r3_nm[9] || (r3_nm[8:0] != 0) || r3_nm[11]);
                    mr = {1'b0, r3_nm[63:11]} + {53'd0, rup};
                    ex = 11'd1023 - {4'd0, r3_lz};
                    if (mr[53]) ex = ex + 11'd1;
                    res = {r3_neg, ex, mr[53] ? 52'd0 : mr[51:0]};
                end
            end
            K_HALF: begin
                if (he == 5'd0) begin
                    if (hm == 10'd0) res = {r3_neg, 63'd0};
                    else res = {r3_neg, 11'd1062 - {4'd0, r3_lz},
                                r3_nm[62:11]};
                end else begin
                    res = {r3_neg, 11'd1008 + {6'd0, he}, hm, 42'd0};
                end
            end
            K_SGL: begin
                if (se == 8'hff)
                    res = {r3_neg, 11'h7ff, (sm != 0) | sm[22], sm[21:0], 29'd0};
                else if (se == 8'd0) begin
                    if (sm == 0) res = {r3_neg, 63'd0};
                    else res = {r3_neg, 11'd937 - {4'd0, r3_lz},
                                r3_nm[62:11]};
                end else res = {r3_neg, 11'd896 + {3'd0, se}, sm, 29'd0};
            end
            K_DBL:   res = r3_w;
            default: res = 64'd0;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_value_bits <= res; o_last_value <= r3_l;
        end
    end
endmodule

/* rtl/core/sample_word_to_double_unit.sv */
// ----------------------------------------------------------------------------
// sample word to double unit
// converts raw integer or float words into double precision bit patterns
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// input     in         i_valid/o_stall  i_raw_word, i_last_word
// output    out        o_valid/i_stall  o_value_bits, o_last_value
// config    in         apb              big_endian, word_bytes, is_float
// one request per cycle while o_stall is low; a request passes the three pipeline
// stages and then the output register
// a stalled output freezes the whole pipeline; nothing is lost or repeated
// reset clears the valid chain and sets word_bytes to four
`timescale 1ns / 1ps
`include "sample_word_to_double_unit_defines.svh"
module sample_word_to_double_unit
    import swd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_raw_word,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_value_bits,
    output logic        o_last_value
);
    t_cfg r_cfg;
    logic wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{big_endian: 1'b0, word_bytes: 4'd4, is_float: 1'b0};
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_BIG_ENDIAN: r_cfg.big_endian <= pwdata[0];
                REG_WORD_BYTES: r_cfg.word_bytes <= pwdata[3:0];
                REG_IS_FLOAT:   r_cfg.is_float   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BIG_ENDIAN: prdata = {31'd0, r_cfg.big_endian};
            REG_WORD_BYTES: prdata = {28'd0, r_cfg.word_bytes};
            REG_IS_FLOAT:   prdata = {31'd0, r_cfg.is_float};
            default:        prdata = 32'd0;
        endcase
    end

    swd_conv u_conv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_valid), .i_raw_word(i_raw_word), .i_last_word(i_last_word),
        .o_stall(o_stall), .o_valid(o_valid), .o_value_bits(o_value_bits),
        .o_last_value(o_last_value), .i_stall(i_stall)
    );

    `SWD_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, o_stall |-> o_valid)
    `SWD_ASSERT(a_hold_out, i_clk, i_rst_n, (o_valid && i_stall) |=> $stable(o_value_bits))
    `SWD_ASSERT(a_cfg_ok, i_clk, i_rst_n, r_cfg.word_bytes <= 4'd15)
endmodule
